// ===== hdl/dvf_pkg.sv =====
// Shared types and constants for the duplicate value finder.
package dvf_pkg;

   localparam int Capacity = 16;
   localparam int MaxDups  = 8;
   localparam int DupAw    = $clog2(MaxDups);
   localparam int DupCntW  = $clog2(MaxDups + 1);
   localparam int ValueW   = 32;

   typedef enum logic [3:0] {
      ST_LOAD,
      ST_FETCH,
      ST_LATCH,
      ST_SCAN,
      ST_SETTLE,
      ST_DECIDE,
      ST_EMIT_RD,
      ST_EMIT_LD,
      ST_EMIT_NONE
   } state_type;

endpackage

// ===== hdl/dvf_ram.sv =====
// Generic simple dual-port RAM with registered read data.
module dvf_ram #(
   parameter int WIDTH  = 32,
   parameter int DEPTH  = 16,
   parameter int ADDR_W = $clog2(DEPTH)
) (
   input  logic              clock,
   input  logic              wr_en,
   input  logic [ADDR_W-1:0] wr_addr,
   input  logic [WIDTH-1:0]  wr_data,
   input  logic [ADDR_W-1:0] rd_addr,
   output logic [WIDTH-1:0]  rd_data
);

   logic [WIDTH-1:0] mem_ff [DEPTH];
   logic [WIDTH-1:0] rd_data_ff;

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem_ff[wr_addr] <= wr_data;
      end
      rd_data_ff <= mem_ff[rd_addr];
   end

   assign rd_data = rd_data_ff;

endmodule

// ===== hdl/duplicate_value_finder.sv =====
// Top level: loads a set of values into RAM, walks it for duplicates, emits each once.
// Loading: one item per cycle while the block is in its load state, no result.
// Closing item: the compare walk reads every stored value against each one in turn,
// through the single read port of the element RAM (one compare per cycle).
// Results then leave in turn through the read and load emit states, held by any stall; the next set loads
// while the last result still waits. Synchronous reset empties the set; no RAM clear.
module duplicate_value_finder #(
   parameter int CAPACITY = dvf_pkg::Capacity
) (
   input  logic        clock,
   input  logic        reset,
   input  logic        req_valid,
   output logic        req_stall,
   input  logic [31:0] req_sample_value,
   input  logic        req_is_final,
   output logic        rsp_valid,
   input  logic        rsp_stall,
   output logic [31:0] rsp_dup_value,
   output logic        rsp_found,
   output logic        rsp_overflow,
   output logic        rsp_run_end
);

   localparam int CNT_W = $clog2(CAPACITY + 1);
   localparam int AW    = $clog2(CAPACITY);

   dvf_pkg::state_type state_ff, state_in;

   logic [CNT_W-1:0]            count_ff, count_in;
   logic [CNT_W-1:0]            i_ff, i_in;
   logic [CNT_W-1:0]            j_ff, j_in;
   logic [AW-1:0]               jd_ff, jd_in;
   logic                        scan_vld_ff, scan_vld_in;
   logic                        earlier_ff, earlier_in;
   logic                        later_ff, later_in;
   logic                        ovf_ff, ovf_in;
   logic [dvf_pkg::DupCntW-1:0] dcnt_ff, dcnt_in;
   logic [dvf_pkg::DupCntW-1:0] k_ff, k_in;
   logic [dvf_pkg::ValueW-1:0]  cur_ff, cur_in;

   logic                        rsp_valid_ff, rsp_valid_in;
   logic [dvf_pkg::ValueW-1:0]  rsp_value_ff, rsp_value_in;
   logic                        rsp_found_ff, rsp_found_in;
   logic                        rsp_ovf_ff, rsp_ovf_in;
   logic                        rsp_end_ff, rsp_end_in;

   logic                        req_accept;
   logic                        out_free;
   logic                        room;
   logic                        is_dup;
   logic                        dup_full;
   logic                        walk_done;
   logic                        last_emit;
   logic                        hit;
   logic [dvf_pkg::DupCntW-1:0] dcnt_next;

   logic                        el_wr_en;
   logic [AW-1:0]               el_rd_addr;
   logic [dvf_pkg::ValueW-1:0]  el_rd_data;
   logic                        dup_wr_en;
   logic [dvf_pkg::DupAw-1:0]   dup_rd_addr;
   logic [dvf_pkg::ValueW-1:0]  dup_rd_data;

   assign req_stall  = (state_ff != dvf_pkg::ST_LOAD);
   assign req_accept = req_valid && !req_stall;
   assign out_free   = !rsp_valid_ff || !rsp_stall;
   assign room       = (count_ff < CNT_W'(CAPACITY));
   assign is_dup     = !earlier_ff && later_ff;
   assign dcnt_next  = dcnt_ff + {{(dvf_pkg::DupCntW-1){1'b0}}, is_dup};
   assign dup_full   = (dcnt_next == dvf_pkg::DupCntW'(dvf_pkg::MaxDups));
   assign walk_done  = ((i_ff + 1'b1) == count_ff) || dup_full;
   assign last_emit  = ((k_ff + 1'b1) == dcnt_ff);
   assign hit        = scan_vld_ff && (el_rd_data == cur_ff);

   dvf_ram #(
      .WIDTH (dvf_pkg::ValueW),
      .DEPTH (CAPACITY)
   ) u_elem_ram (
      .clock   (clock),
      .wr_en   (el_wr_en),
      .wr_addr (count_ff[AW-1:0]),
      .wr_data (req_sample_value),
      .rd_addr (el_rd_addr),
      .rd_data (el_rd_data)
   );

   dvf_ram #(
      .WIDTH (dvf_pkg::ValueW),
      .DEPTH (dvf_pkg::MaxDups)
   ) u_dup_ram (
      .clock   (clock),
      .wr_en   (dup_wr_en),
      .wr_addr (dcnt_ff[dvf_pkg::DupAw-1:0]),
      .wr_data (cur_ff),
      .rd_addr (dup_rd_addr),
      .rd_data (dup_rd_data)
   );

   always_comb begin
      state_in = state_ff;
      unique case (state_ff)
         dvf_pkg::ST_LOAD: begin
            if (req_accept && req_is_final) begin
               state_in = dvf_pkg::ST_FETCH;
            end
         end
         dvf_pkg::ST_FETCH:  state_in = dvf_pkg::ST_LATCH;
         dvf_pkg::ST_LATCH:  state_in = dvf_pkg::ST_SCAN;
         dvf_pkg::ST_SCAN: begin
            if ((j_ff + 1'b1) == count_ff) begin
               state_in = dvf_pkg::ST_SETTLE;
            end
         end
         dvf_pkg::ST_SETTLE: state_in = dvf_pkg::ST_DECIDE;
         dvf_pkg::ST_DECIDE: begin
            if (!walk_done) begin
               state_in = dvf_pkg::ST_FETCH;
            end else if (dcnt_next == '0) begin
               state_in = dvf_pkg::ST_EMIT_NONE;
            end else begin
               state_in = dvf_pkg::ST_EMIT_RD;
            end
         end
         dvf_pkg::ST_EMIT_RD: begin
            if (out_free) begin
               state_in = dvf_pkg::ST_EMIT_LD;
            end
         end
         dvf_pkg::ST_EMIT_LD: begin
            state_in = last_emit ? dvf_pkg::ST_LOAD : dvf_pkg::ST_EMIT_RD;
         end
         dvf_pkg::ST_EMIT_NONE: begin
            if (out_free) begin
               state_in = dvf_pkg::ST_LOAD;
            end
         end
         default: state_in = dvf_pkg::ST_LOAD;
      endcase
   end

   always_comb begin
      count_in     = count_ff;
      i_in         = i_ff;
      j_in         = j_ff;
      jd_in        = j_ff[AW-1:0];
      scan_vld_in  = 1'b0;
      earlier_in   = earlier_ff || (hit && (jd_ff < i_ff[AW-1:0]));
      later_in     = later_ff   || (hit && (jd_ff > i_ff[AW-1:0]));
      ovf_in       = ovf_ff;
      dcnt_in      = dcnt_ff;
      k_in         = k_ff;
      cur_in       = cur_ff;
      el_wr_en     = 1'b0;
      el_rd_addr   = j_ff[AW-1:0];
      dup_wr_en    = 1'b0;
      dup_rd_addr  = k_ff[dvf_pkg::DupAw-1:0];
      rsp_valid_in = rsp_valid_ff && rsp_stall;
      rsp_value_in = rsp_value_ff;
      rsp_found_in = rsp_found_ff;
      rsp_ovf_in   = rsp_ovf_ff;
      rsp_end_in   = rsp_end_ff;
      unique case (state_ff)
         dvf_pkg::ST_LOAD: begin
            if (req_accept) begin
               if (room) begin
                  el_wr_en = 1'b1;
                  count_in = count_ff + 1'b1;
               end else begin
                  ovf_in = 1'b1;
               end
               i_in    = '0;
               dcnt_in = '0;
            end
         end
         dvf_pkg::ST_FETCH: begin
            el_rd_addr = i_ff[AW-1:0];
         end
         dvf_pkg::ST_LATCH: begin
            cur_in     = el_rd_data;
            j_in       = '0;
            earlier_in = 1'b0;
            later_in   = 1'b0;
         end
         dvf_pkg::ST_SCAN: begin
            scan_vld_in = 1'b1;
            j_in        = j_ff + 1'b1;
         end
         dvf_pkg::ST_SETTLE: begin
         end
         dvf_pkg::ST_DECIDE: begin
            dup_wr_en = is_dup;
            dcnt_in   = dcnt_next;
            i_in      = i_ff + 1'b1;
            k_in      = '0;
         end
         dvf_pkg::ST_EMIT_RD: begin
         end
         dvf_pkg::ST_EMIT_LD: begin
            rsp_valid_in = 1'b1;
            rsp_value_in = dup_rd_data;
            rsp_found_in = 1'b1;
            rsp_ovf_in   = ovf_ff;
            rsp_end_in   = last_emit;
            k_in         = k_ff + 1'b1;
            if (last_emit) begin
               count_in = '0;
               dcnt_in  = '0;
               ovf_in   = 1'b0;
            end
         end
         dvf_pkg::ST_EMIT_NONE: begin
            if (out_free) begin
               rsp_valid_in = 1'b1;
               rsp_value_in = '0;
               rsp_found_in = 1'b0;
               rsp_ovf_in   = ovf_ff;
               rsp_end_in   = 1'b1;
               count_in     = '0;
               dcnt_in      = '0;
               ovf_in       = 1'b0;
            end
         end
         default: begin
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= dvf_pkg::ST_LOAD;
         count_ff     <= '0;
         i_ff         <= '0;
         j_ff         <= '0;
         scan_vld_ff  <= 1'b0;
         earlier_ff   <= 1'b0;
         later_ff     <= 1'b0;
         ovf_ff       <= 1'b0;
         dcnt_ff      <= '0;
         k_ff         <= '0;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         count_ff     <= count_in;
         i_ff         <= i_in;
         j_ff         <= j_in;
         scan_vld_ff  <= scan_vld_in;
         earlier_ff   <= earlier_in;
         later_ff     <= later_in;
         ovf_ff       <= ovf_in;
         dcnt_ff      <= dcnt_in;
         k_ff         <= k_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      jd_ff        <= jd_in;
      cur_ff       <= cur_in;
      rsp_value_ff <= rsp_value_in;
      rsp_found_ff <= rsp_found_in;
      rsp_ovf_ff   <= rsp_ovf_in;
      rsp_end_ff   <= rsp_end_in;
   end

   assign rsp_valid     = rsp_valid_ff;
   assign rsp_dup_value = rsp_value_ff;
   assign rsp_found     = rsp_found_ff;
   assign rsp_overflow  = rsp_ovf_ff;
   assign rsp_run_end   = rsp_end_ff;

   a_dcnt_bound: assert property (@(posedge clock) disable iff (reset)
      dcnt_ff <= dvf_pkg::DupCntW'(dvf_pkg::MaxDups))
      else $error("duplicate count beyond list size");

   a_count_bound: assert property (@(posedge clock) disable iff (reset)
      count_ff <= CNT_W'(CAPACITY))
      else $error("element count beyond capacity");

   a_none_is_end: assert property (@(posedge clock) disable iff (reset)
      rsp_valid_ff && !rsp_found_ff |-> rsp_end_ff)
      else $error("empty result without run end");

   a_load_free: assert property (@(posedge clock) disable iff (reset)
      (state_ff == dvf_pkg::ST_EMIT_LD) |-> !rsp_valid_ff)
      else $error("result register overwritten");

endmodule

// ===== test/tb_duplicate_value_finder.sv =====
// Testbench for the duplicate value finder: directed and random sets checked by a predictor.
`timescale 1ns / 100ps

module tb_duplicate_value_finder;

   localparam int CycleLimit  = 200000;
   localparam int RandomItems = 250;

   typedef struct {
      logic signed [31:0] dup_value;
      logic               found;
      logic               overflow;
      logic               run_end;
   } dup_result_type;

   logic        clock = 1'b0;
   logic        reset = 1'b1;
   logic        req_valid = 1'b0;
   logic        req_stall;
   logic [31:0] req_sample_value = '0;
   logic        req_is_final = 1'b0;
   logic        rsp_valid;
   logic        rsp_stall = 1'b0;
   logic [31:0] rsp_dup_value;
   logic        rsp_found;
   logic        rsp_overflow;
   logic        rsp_run_end;

   dup_result_type     expected_dups[$];
   logic signed [31:0] set_values[$];
   logic               set_overflow = 1'b0;
   int                 error_count = 0;
   int                 cycle_count = 0;
   int                 items_sent = 0;
   bit                 tx_burst = 1'b0;
   bit                 rx_burst = 1'b0;
   int                 rx_hold = 0;

   duplicate_value_finder dut (
      .clock           (clock),
      .reset           (reset),
      .req_valid       (req_valid),
      .req_stall       (req_stall),
      .req_sample_value(req_sample_value),
      .req_is_final    (req_is_final),
      .rsp_valid       (rsp_valid),
      .rsp_stall       (rsp_stall),
      .rsp_dup_value   (rsp_dup_value),
      .rsp_found       (rsp_found),
      .rsp_overflow    (rsp_overflow),
      .rsp_run_end     (rsp_run_end)
   );

   always begin
      #10 clock = 1'b1;
      #10 clock = 1'b0;
   end

   always @(posedge clock) begin
      cycle_count++;
      if (cycle_count > CycleLimit) begin
         $display("tb_duplicate_value_finder failed");
         $finish;
      end
   end

   // Store one sample; on the closing sample list the repeated values in first-seen order.
   function automatic void collect_sample(input logic signed [31:0] value, input logic fin);
      logic signed [31:0] dups[$];
      bit                 repeated;
      bit                 listed;
      if (set_values.size() < dvf_pkg::Capacity)
         set_values.push_back(value);
      else
         set_overflow = 1'b1;
      if (!fin)
         return;
      for (int i = 0; i < set_values.size(); i++) begin
         if (dups.size() >= dvf_pkg::MaxDups)
            break;
         repeated = 1'b0;
         listed = 1'b0;
         for (int k = 0; k < set_values.size(); k++)
            if (k != i && set_values[k] == set_values[i])
               repeated = 1'b1;
         foreach (dups[k])
            if (dups[k] == set_values[i])
               listed = 1'b1;
         if (repeated && !listed)
            dups.push_back(set_values[i]);
      end
      if (dups.size() == 0) begin
         expected_dups.push_back('{32'sd0, 1'b0, set_overflow, 1'b1});
      end else begin
         foreach (dups[i])
            expected_dups.push_back('{dups[i], 1'b1, set_overflow, i == dups.size() - 1});
      end
      set_values.delete();
      set_overflow = 1'b0;
   endfunction

   task automatic send_sample(input logic [31:0] value, input logic fin);
      int gap;
      gap = tx_burst ? 0 : $urandom_range(0, 16);
      if (gap > 0) begin
         req_valid <= 1'b0;
         repeat (gap) @(posedge clock);
      end
      req_valid <= 1'b1;
      req_sample_value <= value;
      req_is_final <= fin;
      do @(posedge clock); while (req_stall);
      collect_sample(value, fin);
      items_sent++;
   endtask

   always @(posedge clock) begin
      dup_result_type want;
      if (!reset && rsp_valid && !rsp_stall) begin
         if (expected_dups.size() == 0) begin
            $error("result dup_value %0d arrived with none expected", $signed(rsp_dup_value));
            error_count++;
         end else begin
            want = expected_dups.pop_front();
            if (rsp_dup_value !== want.dup_value) begin
               $error("dup_value expected %0d actual %0d", want.dup_value,
                      $signed(rsp_dup_value));
               error_count++;
            end
            if (rsp_found !== want.found) begin
               $error("found expected %0b actual %0b", want.found, rsp_found);
               error_count++;
            end
            if (rsp_overflow !== want.overflow) begin
               $error("overflow expected %0b actual %0b", want.overflow, rsp_overflow);
               error_count++;
            end
            if (rsp_run_end !== want.run_end) begin
               $error("run_end expected %0b actual %0b", want.run_end, rsp_run_end);
               error_count++;
            end
         end
         if ($urandom_range(0, 7) == 0)
            rx_burst = !rx_burst;
         rx_hold = rx_burst ? 0 : $urandom_range(0, 16);
      end else if (rsp_valid && rx_hold > 0) begin
         rx_hold--;
      end
      rsp_stall <= (rx_hold != 0);
   end

   task automatic test_lone_value();
      send_sample(32'h0000_0000, 1'b1);
   endtask

   task automatic test_extremes_and_repeats();
      tx_burst = 1'b1;
      send_sample(32'h8000_0000, 1'b0);
      send_sample(32'h7fff_ffff, 1'b0);
      send_sample(32'hffff_ffff, 1'b0);
      send_sample(32'h7fff_ffff, 1'b0);
      send_sample(32'h8000_0000, 1'b0);
      send_sample(32'h8000_0000, 1'b1);
      tx_burst = 1'b0;
   endtask

   // Fill the store with eight pairs, then overrun it; the closing item is dropped too.
   task automatic test_full_set_overflow();
      logic [31:0] pairs[8];
      pairs = '{32'd1, 32'hffff_fffe, 32'd3, 32'h8000_0000,
                32'h7fff_ffff, 32'd0, 32'hffff_ffff, 32'h5555_aaaa};
      for (int i = 0; i < 8; i++)
         send_sample(pairs[i], 1'b0);
      for (int i = 7; i >= 0; i--)
         send_sample(pairs[i], 1'b0);
      send_sample(32'd100, 1'b0);
      send_sample(32'd200, 1'b1);
   endtask

   task automatic test_random_sets();
      logic [31:0] pool[8];
      int          pool_used;
      int          set_size;
      int          start;
      logic [31:0] value;
      start = items_sent;
      while (items_sent - start < RandomItems) begin
         tx_burst = ($urandom_range(0, 3) == 0);
         set_size = ($urandom_range(0, 7) == 0)
                    ? $urandom_range(dvf_pkg::Capacity, dvf_pkg::Capacity + 4)
                    : $urandom_range(1, 10);
         pool_used = $urandom_range(1, 8);
         foreach (pool[i])
            pool[i] = $urandom_range(0, 1) ? $urandom() : $urandom_range(0, 3) - 2;
         for (int i = 0; i < set_size; i++) begin
            value = ($urandom_range(0, 2) == 0) ? $urandom()
                                                : pool[$urandom_range(0, pool_used - 1)];
            send_sample(value, i == set_size - 1);
         end
      end
      tx_burst = 1'b0;
   endtask

   initial begin
      repeat (2) @(posedge clock);
      reset <= 1'b0;
      test_lone_value();
      test_extremes_and_repeats();
      test_full_set_overflow();
      test_random_sets();
      req_valid <= 1'b0;
      while (expected_dups.size() != 0)
         @(posedge clock);
      repeat (50) @(posedge clock);
      if (error_count == 0)
         $display("tb_duplicate_value_finder passed");
      else
         $display("tb_duplicate_value_finder failed");
      $finish;
   end

endmodule
